### design/rabs_pkg.sv
// Shared types and constants of the running-average background subtractor.
`timescale 1ns / 1ps

package rabs_pkg;

    localparam int CH_N      = 3;
    localparam int SAMPLE_W  = 8;
    localparam int INDEX_W   = 19;
    localparam int WEIGHT_W  = 16;
    localparam int FACTOR_W  = 16;
    localparam int T2_W      = 2 * FACTOR_W;
    localparam int RHS_W     = T2_W + SAMPLE_W;
    localparam int DSQ_W     = 2 * SAMPLE_W;
    localparam int CFG_IDX_W = 1;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_FACTOR = 1'b1;

    localparam logic [WEIGHT_W-1:0] BLEND_RESET  = 16'd3277;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd51;

    // channel 0 is blue, channel 2 is red
    typedef logic [CH_N-1:0][SAMPLE_W-1:0] t_rgb;

    typedef struct packed {
        logic valid;
        logic kind;
        logic inrange;
    } t_ctl;

    typedef struct packed {
        logic mark;
        t_rgb variance;
        t_rgb bg;
    } t_word;

    localparam t_word CLEAR_WORD = '{mark: 1'b1, variance: 24'h010101, bg: 24'h000000};

endpackage

### design/rabs_store.sv
// Per-pixel model store with a clearing pass after reset.
`timescale 1ns / 1ps

module rabs_store import rabs_pkg::*; #(
    parameter int DEPTH  = 307200,
    parameter int ADDR_W = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_word             o_rd_word,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_word             i_wr_word,
    output logic              o_clearing
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    t_word             mem [DEPTH];
    t_word             r_rd_word;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= CLEAR_WORD;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_word;
        end
        if (i_rd_en) begin
            r_rd_word <= mem[i_rd_addr];
        end
    end

    assign o_rd_word  = r_rd_word;
    assign o_clearing = r_clearing;

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !r_clearing)
        else $error("store written during clearing pass");

    a_clear_ends_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_addr) == LAST_ADDR)
        else $error("clearing pass ended early");

    a_clear_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> r_clr_addr <= LAST_ADDR)
        else $error("clearing address beyond depth");

endmodule

### design/rabs_update.sv
// Three-stage blend of background and variance.
`timescale 1ns / 1ps

module rabs_update import rabs_pkg::*; #(
    parameter int ADDR_W = 19
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  t_ctl                i_ctl,
    input  logic [ADDR_W-1:0]   i_addr,
    input  t_rgb                i_px,
    input  t_word               i_word,
    input  logic [ADDR_W-1:0]   i_probe_addr,
    output logic                o_hit,
    output t_ctl                o_ctl,
    output logic [ADDR_W-1:0]   o_addr,
    output t_rgb                o_px,
    output t_rgb                o_bg,
    output t_rgb                o_var,
    output logic                o_mark
);

    localparam int PA_W = WEIGHT_W + SAMPLE_W;
    localparam int PB_W = WEIGHT_W + 1 + SAMPLE_W;

    function automatic logic [SAMPLE_W-1:0] blend_sum(input logic [PA_W-1:0] pa,
                                                      input logic [PB_W-1:0] pb);
        logic [SAMPLE_W:0] ra;
        logic [SAMPLE_W:0] rb;
        logic [SAMPLE_W:0] s;
        ra = (SAMPLE_W + 1)'(((PA_W + 1)'(pa) + (PA_W + 1)'(32768)) >> 16);
        rb = (SAMPLE_W + 1)'(((PB_W + 1)'(pb) + (PB_W + 1)'(32768)) >> 16);
        s  = ra + rb;
        return (s > (SAMPLE_W + 1)'(255)) ? {SAMPLE_W{1'b1}} : s[SAMPLE_W-1:0];
    endfunction

    logic [WEIGHT_W:0] w_inv_weight;

    // stage 2: squared difference and background products
    t_ctl                           r2_ctl;
    logic [ADDR_W-1:0]              r2_addr;
    t_rgb                           r2_px, r2_bg, r2_var;
    logic                           r2_mark;
    logic [CH_N-1:0][DSQ_W-1:0]     r2_dd, n2_dd;
    logic [CH_N-1:0][PA_W-1:0]      r2_pa, n2_pa;
    logic [CH_N-1:0][PB_W-1:0]      r2_pb, n2_pb;

    // stage 3: new background and variance products
    t_ctl                           r3_ctl;
    logic [ADDR_W-1:0]              r3_addr;
    t_rgb                           r3_px, r3_var, r3_bg, n3_bg;
    logic                           r3_mark, r3_upd, n3_upd;
    logic [CH_N-1:0][PA_W-1:0]      r3_qa, n3_qa;
    logic [CH_N-1:0][PB_W-1:0]      r3_qb, n3_qb;

    // stage 4: new variance
    t_ctl                           r4_ctl;
    logic [ADDR_W-1:0]              r4_addr;
    t_rgb                           r4_px, r4_bg, r4_var, n4_var;
    logic                           r4_mark;

    assign w_inv_weight = (WEIGHT_W + 1)'(65536) - {1'b0, i_weight};

    always_comb begin
        logic [SAMPLE_W-1:0] diff;
        for (int k = 0; k < CH_N; k++) begin
            diff     = (i_px[k] > i_word.bg[k]) ? i_px[k] - i_word.bg[k]
                                                : i_word.bg[k] - i_px[k];
            n2_dd[k] = {{SAMPLE_W{1'b0}}, diff} * {{SAMPLE_W{1'b0}}, diff};
            n2_pa[k] = {{SAMPLE_W{1'b0}}, i_weight} * {{WEIGHT_W{1'b0}}, i_px[k]};
            n2_pb[k] = {{SAMPLE_W{1'b0}}, w_inv_weight}
                     * {{(WEIGHT_W + 1){1'b0}}, i_word.bg[k]};
        end
    end

    always_comb begin
        logic [SAMPLE_W-1:0] sq;
        n3_upd = (r2_ctl.kind == KIND_UPDATE) && r2_mark;
        for (int k = 0; k < CH_N; k++) begin
            sq       = (r2_dd[k] > DSQ_W'(255)) ? {SAMPLE_W{1'b1}} : r2_dd[k][SAMPLE_W-1:0];
            n3_qa[k] = {{SAMPLE_W{1'b0}}, i_weight} * {{WEIGHT_W{1'b0}}, sq};
            n3_qb[k] = {{SAMPLE_W{1'b0}}, w_inv_weight} * {{(WEIGHT_W + 1){1'b0}}, r2_var[k]};
            if (r2_ctl.kind == KIND_LOAD) begin
                n3_bg[k] = r2_px[k];
            end else if (n3_upd) begin
                n3_bg[k] = blend_sum(r2_pa[k], r2_pb[k]);
            end else begin
                n3_bg[k] = r2_bg[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < CH_N; k++) begin
            n4_var[k] = r3_upd ? blend_sum(r3_qa[k], r3_qb[k]) : r3_var[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= i_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_addr <= i_addr;
            r2_px   <= i_px;
            r2_bg   <= i_word.bg;
            r2_var  <= i_word.variance;
            r2_mark <= i_word.mark;
            r2_dd   <= n2_dd;
            r2_pa   <= n2_pa;
            r2_pb   <= n2_pb;

            r3_addr <= r2_addr;
            r3_px   <= r2_px;
            r3_var  <= r2_var;
            r3_mark <= r2_mark;
            r3_upd  <= n3_upd;
            r3_bg   <= n3_bg;
            r3_qa   <= n3_qa;
            r3_qb   <= n3_qb;

            r4_addr <= r3_addr;
            r4_px   <= r3_px;
            r4_bg   <= r3_bg;
            r4_var  <= n4_var;
            r4_mark <= r3_mark;
        end
    end

    assign o_hit = (r2_ctl.valid && r2_ctl.inrange && (r2_addr == i_probe_addr))
                || (r3_ctl.valid && r3_ctl.inrange && (r3_addr == i_probe_addr))
                || (r4_ctl.valid && r4_ctl.inrange && (r4_addr == i_probe_addr));

    assign o_ctl  = r4_ctl;
    assign o_addr = r4_addr;
    assign o_px   = r4_px;
    assign o_bg   = r4_bg;
    assign o_var  = r4_var;
    assign o_mark = r4_mark;

endmodule

### design/rabs_classify.sv
// Deviation test and two-of-three channel vote.
`timescale 1ns / 1ps

module rabs_classify import rabs_pkg::*; #(
    parameter int ADDR_W = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [T2_W-1:0]   i_t2,
    input  t_ctl              i_ctl,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_rgb              i_px,
    input  t_rgb              i_bg,
    input  t_rgb              i_var,
    input  logic              i_mark,
    input  logic [ADDR_W-1:0] i_probe_addr,
    output logic              o_hit,
    output t_ctl              o_ctl,
    output logic [ADDR_W-1:0] o_addr,
    output t_rgb              o_bg,
    output t_rgb              o_var,
    output logic              o_mark,
    output logic              o_fg
);

    t_ctl                        r5_ctl;
    logic [ADDR_W-1:0]           r5_addr;
    t_rgb                        r5_bg, r5_var;
    logic                        r5_mark;
    logic [CH_N-1:0][DSQ_W-1:0]  r5_dsq, n5_dsq;
    logic [CH_N-1:0][RHS_W-1:0]  r5_rhs, n5_rhs;
    logic [CH_N-1:0]             w_exceed;

    always_comb begin
        logic [SAMPLE_W-1:0] diff;
        for (int k = 0; k < CH_N; k++) begin
            diff      = (i_px[k] > i_bg[k]) ? i_px[k] - i_bg[k] : i_bg[k] - i_px[k];
            n5_dsq[k] = {{SAMPLE_W{1'b0}}, diff} * {{SAMPLE_W{1'b0}}, diff};
            n5_rhs[k] = {{SAMPLE_W{1'b0}}, i_t2} * {{T2_W{1'b0}}, i_var[k]};
        end
    end

    // (256*d)^2 against t^2 * variance
    always_comb begin
        for (int k = 0; k < CH_N; k++) begin
            w_exceed[k] = {{(RHS_W - DSQ_W - 16){1'b0}}, r5_dsq[k], 16'h0000} > r5_rhs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl <= '0;
        end else if (i_en) begin
            r5_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_addr <= i_addr;
            r5_bg   <= i_bg;
            r5_var  <= i_var;
            r5_mark <= i_mark;
            r5_dsq  <= n5_dsq;
            r5_rhs  <= n5_rhs;
        end
    end

    assign o_hit  = r5_ctl.valid && r5_ctl.inrange && (r5_addr == i_probe_addr);
    assign o_ctl  = r5_ctl;
    assign o_addr = r5_addr;
    assign o_bg   = r5_bg;
    assign o_var  = r5_var;
    assign o_mark = r5_mark;
    assign o_fg   = (w_exceed[0] && w_exceed[1]) || (w_exceed[0] && w_exceed[2])
                 || (w_exceed[1] && w_exceed[2]);

endmodule

### design/running_average_background_subtractor_core.sv
// Path: an accepted word passes the store read, update, classify and result registers.
// Throughput: one pixel word per cycle while the result channel is not stalled; a word
//   whose pixel is still in flight waits until that pixel has been written back.
// Reset: synchronous, active low; afterwards the store is swept one entry a cycle over
//   all FRAME_PIXELS entries, while input is stalled and configuration is taken.
`timescale 1ns / 1ps

module running_average_background_subtractor_core import rabs_pkg::*; #(
    parameter int FRAME_PIXELS = 307200
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_kind,
    input  logic [INDEX_W-1:0]   i_pixel_index,
    input  logic [SAMPLE_W-1:0]  i_red,
    input  logic [SAMPLE_W-1:0]  i_green,
    input  logic [SAMPLE_W-1:0]  i_blue,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SAMPLE_W-1:0]  o_bg_red,
    output logic [SAMPLE_W-1:0]  o_bg_green,
    output logic [SAMPLE_W-1:0]  o_bg_blue,
    output logic                 o_is_foreground,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data
);

    // Store address and the width the raw index is compared at.
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
    localparam int IW = ($clog2(FRAME_PIXELS + 1) > INDEX_W) ? $clog2(FRAME_PIXELS + 1)
                                                             : INDEX_W;

    // configuration
    logic [WEIGHT_W-1:0] r_blend_weight;
    logic [FACTOR_W-1:0] r_dev_factor;
    logic [T2_W-1:0]     r_t2;

    // input decode
    logic [IW-1:0]       w_idx_ext;
    logic                w_inrange;
    logic [AW-1:0]       w_addr;
    t_rgb                w_px;
    logic                w_en;
    logic                w_accept;
    logic                w_hazard;
    logic                w_clearing;

    // stage 1: store read in flight
    t_ctl                r_s1_ctl;
    logic [AW-1:0]       r_s1_addr;
    t_rgb                r_s1_px;
    t_word               w_rd_word;

    // update stages
    logic                w_upd_hit;
    t_ctl                w_upd_ctl;
    logic [AW-1:0]       w_upd_addr;
    t_rgb                w_upd_px, w_upd_bg, w_upd_var;
    logic                w_upd_mark;

    // classify stage
    logic                w_cls_hit;
    t_ctl                w_cls_ctl;
    logic [AW-1:0]       w_cls_addr;
    t_rgb                w_cls_bg, w_cls_var;
    logic                w_cls_mark;
    logic                w_cls_fg;

    // write back and result
    logic                w_wr_en;
    t_word               w_wr_word;
    logic                w_fg;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_bg_red, r_bg_green, r_bg_blue;
    logic                r_is_fg;

    // Configuration is always taken; t^2 is kept ready for the threshold product.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= BLEND_RESET;
            r_dev_factor   <= FACTOR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BLEND_WEIGHT:     r_blend_weight <= i_cfg_data;
                REG_DEVIATION_FACTOR: r_dev_factor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_t2 <= {{FACTOR_W{1'b0}}, r_dev_factor} * {{FACTOR_W{1'b0}}, r_dev_factor};
    end

    // Index check: anything past the frame passes through untouched as zeros.
    assign w_idx_ext = IW'(i_pixel_index);
    assign w_inrange = w_idx_ext < IW'(FRAME_PIXELS);
    assign w_addr    = w_idx_ext[AW-1:0];
    assign w_px      = {i_red, i_green, i_blue};

    // The whole pipe advances together whenever the result register can move.
    assign w_en = !r_out_valid || !i_stall;

    // Hold a word back while an earlier word for the same pixel has not yet
    // been written back; the store read would otherwise be stale.
    assign w_hazard = w_inrange && ((r_s1_ctl.valid && r_s1_ctl.inrange && (r_s1_addr == w_addr))
                                    || w_upd_hit || w_cls_hit);

    assign o_stall  = w_clearing || !w_en || w_hazard;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (w_en) begin
            r_s1_ctl <= '{valid: w_accept, kind: i_kind, inrange: w_inrange};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_addr <= w_addr;
            r_s1_px   <= w_px;
        end
    end

    rabs_store #(
        .DEPTH  (FRAME_PIXELS),
        .ADDR_W (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_en),
        .i_rd_addr  (w_addr),
        .o_rd_word  (w_rd_word),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_cls_addr),
        .i_wr_word  (w_wr_word),
        .o_clearing (w_clearing)
    );

    rabs_update #(
        .ADDR_W (AW)
    ) u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_weight     (r_blend_weight),
        .i_ctl        (r_s1_ctl),
        .i_addr       (r_s1_addr),
        .i_px         (r_s1_px),
        .i_word       (w_rd_word),
        .i_probe_addr (w_addr),
        .o_hit        (w_upd_hit),
        .o_ctl        (w_upd_ctl),
        .o_addr       (w_upd_addr),
        .o_px         (w_upd_px),
        .o_bg         (w_upd_bg),
        .o_var        (w_upd_var),
        .o_mark       (w_upd_mark)
    );

    rabs_classify #(
        .ADDR_W (AW)
    ) u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_t2         (r_t2),
        .i_ctl        (w_upd_ctl),
        .i_addr       (w_upd_addr),
        .i_px         (w_upd_px),
        .i_bg         (w_upd_bg),
        .i_var        (w_upd_var),
        .i_mark       (w_upd_mark),
        .i_probe_addr (w_addr),
        .o_hit        (w_cls_hit),
        .o_ctl        (w_cls_ctl),
        .o_addr       (w_cls_addr),
        .o_bg         (w_cls_bg),
        .o_var        (w_cls_var),
        .o_mark       (w_cls_mark),
        .o_fg         (w_cls_fg)
    );

    // Write back: a load keeps its old mark, an update stores the new verdict.
    assign w_wr_en             = w_en && w_cls_ctl.valid && w_cls_ctl.inrange;
    assign w_wr_word.mark      = (w_cls_ctl.kind == KIND_LOAD) ? w_cls_mark : !w_cls_fg;
    assign w_wr_word.variance  = w_cls_var;
    assign w_wr_word.bg        = w_cls_bg;

    // Foreground only counts for an in-frame update; it blanks the background.
    assign w_fg = w_cls_ctl.inrange && (w_cls_ctl.kind == KIND_UPDATE) && w_cls_fg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_cls_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_is_fg <= w_fg;
            if (!w_cls_ctl.inrange || w_fg) begin
                r_bg_red   <= '0;
                r_bg_green <= '0;
                r_bg_blue  <= '0;
            end else begin
                r_bg_red   <= w_cls_bg[2];
                r_bg_green <= w_cls_bg[1];
                r_bg_blue  <= w_cls_bg[0];
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_bg_red        = r_bg_red;
    assign o_bg_green      = r_bg_green;
    assign o_bg_blue       = r_bg_blue;
    assign o_is_foreground = r_is_fg;

    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && r_s1_ctl.valid && r_s1_ctl.inrange && (w_cls_addr == r_s1_addr)))
        else $error("write back hits a pixel whose read is in flight");

    a_fg_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_is_fg) |->
            (r_bg_red == '0) && (r_bg_green == '0) && (r_bg_blue == '0))
        else $error("foreground result carries a background");

    a_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> (!r_out_valid && !r_s1_ctl.valid && !w_upd_ctl.valid
                        && !w_cls_ctl.valid))
        else $error("pipe not empty during clearing pass");

endmodule
